// File: rtl/core/crt_pkg.sv
`default_nettype none

package crt_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_BITS    = 16;
    localparam int COUNT_BITS  = 32;

    // widths fixed by the port fields
    localparam int KEY_PORT_BITS = 16;
    localparam int CAP_BITS      = 5;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 5;
    localparam int TOTAL_BITS    = 32;

    localparam int OCC_BITS  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_BITS  = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;
    localparam int BIT_BITS  = 5;
    localparam int SEEN_W    = 32;
    localparam int ROW_BITS  = KEY_BITS - BIT_BITS;
    localparam int SEEN_ROWS = 2 ** ROW_BITS;

    typedef logic [KEY_BITS-1:0]     t_key;
    typedef logic [OCC_BITS-1:0]     t_occ;
    typedef logic [CMP_BITS-1:0]     t_cmp;
    typedef logic [COUNT_BITS-1:0]   t_count;
    typedef logic [ROW_BITS-1:0]     t_row;
    typedef logic [SEEN_W-1:0]       t_seen_word;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_CAPACITY = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_MODE     = t_cfg_idx'(1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

    // broadcast to every cell during the lookup cycle
    typedef struct packed {
        logic upd;
        logic lru;
        logic hit;
        logic full;
        t_occ occ;
    } t_cell_ctl;

    function automatic t_count sat_inc(input t_count c);
        return (c == '1) ? c : c + t_count'(1);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/cache_replacement_tracker.sv
// channel   | ports                                         | handshake
// ----------+-----------------------------------------------+---------------------------
// request   | i_key                                         | i_start && !o_busy
// result    | o_hit o_cold_miss o_evicted o_evicted_key     | o_done, one cycle, no stall
//           | o_hit_total o_miss_total o_cold_total         |
//           | o_reload_total o_evict_total                  |
// config    | i_cfg_idx i_cfg_data                          | i_cfg_we, no wait
//
// A request first reads the seen-map row, then compares the key against the cell row and
// updates cells, counters and the seen map. The result strobes in the cycle after, when
// the next request may already be taken.
// After reset the seen map is swept one 32-bit row a cycle, with o_busy high until the
// sweep ends; config writes are taken during the sweep. The receiver cannot stall.
`default_nettype none

module cache_replacement_tracker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic [crt_pkg::KEY_PORT_BITS-1:0]     i_key,
    input  logic                                  i_cfg_we,
    input  crt_pkg::t_cfg_idx                     i_cfg_idx,
    input  logic [crt_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    output logic                                  o_done,
    output logic                                  o_hit,
    output logic                                  o_cold_miss,
    output logic                                  o_evicted,
    output logic [crt_pkg::KEY_PORT_BITS-1:0]     o_evicted_key,
    output logic [crt_pkg::TOTAL_BITS-1:0]        o_hit_total,
    output logic [crt_pkg::TOTAL_BITS-1:0]        o_miss_total,
    output logic [crt_pkg::TOTAL_BITS-1:0]        o_cold_total,
    output logic [crt_pkg::TOTAL_BITS-1:0]        o_reload_total,
    output logic [crt_pkg::TOTAL_BITS-1:0]        o_evict_total
);
    import crt_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [CAP_BITS-1:0] r_capacity;
    logic                r_mode;
    t_key                r_key;
    t_occ                r_occ;
    t_occ                n_occ;

    t_count r_hit_cnt;
    t_count r_miss_cnt;
    t_count r_cold_cnt;
    t_count r_reload_cnt;
    t_count r_evict_cnt;

    logic                     r_done;
    logic                     r_hit;
    logic                     r_cold;
    logic                     r_evicted;
    logic [KEY_PORT_BITS-1:0] r_ev_key;

    logic busy;
    logic rd_en;
    logic upd;
    logic accept;
    logic clearing;

    t_cmp       cap_ext;
    t_cmp       ucap;
    logic       full;
    logic       hit;
    logic       seen;
    t_seen_word rd_data;
    t_seen_word wr_data;
    logic       wr_en;

    t_cell_ctl                 ctl;
    t_key                      cell_key  [MAX_ENTRIES];
    t_key                      next_key  [MAX_ENTRIES];
    logic [MAX_ENTRIES:0]      sh;
    logic [MAX_ENTRIES-1:0]    match;

    assign accept = i_start && !busy;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (!clearing) n_state = S_IDLE;
            S_IDLE:   if (i_start) n_state = S_LOOKUP;
            S_LOOKUP: n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        busy  = 1'b1;
        rd_en = 1'b0;
        upd   = 1'b0;
        unique case (r_state)
            S_CLEAR:  busy = 1'b1;
            S_IDLE: begin
                busy  = 1'b0;
                rd_en = i_start;
            end
            S_LOOKUP: upd = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_BITS'(16);
            r_mode     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CAPACITY: r_capacity <= i_cfg_data[CAP_BITS-1:0];
                CFG_MODE:     r_mode     <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= i_key[KEY_BITS-1:0];
        end
    end

    // clamp capacity to 1..MAX_ENTRIES
    assign cap_ext = t_cmp'(r_capacity);
    always_comb begin
        ucap = cap_ext;
        if (cap_ext == '0) begin
            ucap = t_cmp'(1);
        end else if (cap_ext > t_cmp'(MAX_ENTRIES)) begin
            ucap = t_cmp'(MAX_ENTRIES);
        end
    end
    assign full = t_cmp'(r_occ) >= ucap;
    assign hit  = |match;

    assign ctl.upd  = upd;
    assign ctl.lru  = r_mode;
    assign ctl.hit  = hit;
    assign ctl.full = full;
    assign ctl.occ  = r_occ;

    assign sh[0] = 1'b0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        if (g == MAX_ENTRIES - 1) begin : g_last
            assign next_key[g] = r_key;
        end else begin : g_mid
            assign next_key[g] = cell_key[g + 1];
        end

        crt_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_idx      (t_occ'(g)),
            .i_key      (r_key),
            .i_next_key (next_key[g]),
            .i_sh       (sh[g]),
            .o_sh       (sh[g + 1]),
            .o_match    (match[g]),
            .o_key      (cell_key[g])
        );
    end

    // seen map: read row on accept, test and set during lookup
    assign seen    = rd_data[r_key[BIT_BITS-1:0]];
    assign wr_data = rd_data | (t_seen_word'(1) << r_key[BIT_BITS-1:0]);
    assign wr_en   = upd && !hit && !seen;

    crt_seen u_seen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_row   (i_key[KEY_BITS-1:BIT_BITS]),
        .o_rd_data  (rd_data),
        .i_wr_en    (wr_en),
        .i_wr_row   (r_key[KEY_BITS-1:BIT_BITS]),
        .i_wr_data  (wr_data),
        .o_clearing (clearing)
    );

    always_comb begin
        n_occ = r_occ;
        if (upd && !hit && !full) begin
            n_occ = r_occ + t_occ'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ        <= '0;
            r_hit_cnt    <= '0;
            r_miss_cnt   <= '0;
            r_cold_cnt   <= '0;
            r_reload_cnt <= '0;
            r_evict_cnt  <= '0;
            r_done       <= 1'b0;
        end else begin
            r_occ  <= n_occ;
            r_done <= upd;
            if (upd) begin
                if (hit) begin
                    r_hit_cnt <= sat_inc(r_hit_cnt);
                end else begin
                    r_miss_cnt <= sat_inc(r_miss_cnt);
                    if (!seen) begin
                        r_cold_cnt <= sat_inc(r_cold_cnt);
                    end else begin
                        r_reload_cnt <= sat_inc(r_reload_cnt);
                    end
                    if (full) begin
                        r_evict_cnt <= sat_inc(r_evict_cnt);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_hit     <= hit;
            r_cold    <= !hit && !seen;
            r_evicted <= !hit && full;
            r_ev_key  <= (!hit && full) ? KEY_PORT_BITS'(cell_key[0]) : '0;
        end
    end

    assign o_busy         = busy;
    assign o_done         = r_done;
    assign o_hit          = r_hit;
    assign o_cold_miss    = r_cold;
    assign o_evicted      = r_evicted;
    assign o_evicted_key  = r_ev_key;
    assign o_hit_total    = r_hit_cnt[TOTAL_BITS-1:0];
    assign o_miss_total   = r_miss_cnt[TOTAL_BITS-1:0];
    assign o_cold_total   = r_cold_cnt[TOTAL_BITS-1:0];
    assign o_reload_total = r_reload_cnt[TOTAL_BITS-1:0];
    assign o_evict_total  = r_evict_cnt[TOTAL_BITS-1:0];

    a_done_after_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_LOOKUP))
        else $error("result strobe without a lookup");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd |-> $onehot0(match))
        else $error("key resident in more than one cell");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= t_occ'(MAX_ENTRIES))
        else $error("occupancy above entry count");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_hit |-> !o_evicted && !o_cold_miss && (o_evicted_key == '0))
        else $error("hit reported with miss fields");

    a_no_lookup_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !upd && !accept)
        else $error("request taken during seen-map sweep");

endmodule

`default_nettype wire

// File: rtl/core/crt_cell.sv
`default_nettype none

module crt_cell (
    input  logic               i_clk,
    input  crt_pkg::t_cell_ctl i_ctl,
    input  crt_pkg::t_occ      i_idx,
    input  crt_pkg::t_key      i_key,
    input  crt_pkg::t_key      i_next_key,
    input  logic               i_sh,
    output logic               o_sh,
    output logic               o_match,
    output crt_pkg::t_key      o_key
);
    import crt_pkg::*;

    t_key r_key;
    t_key n_key;
    logic occupied;
    logic tail;
    logic append;
    logic move;

    assign occupied = i_idx < i_ctl.occ;
    assign tail     = t_occ'(i_idx + t_occ'(1)) == i_ctl.occ;
    assign append   = i_idx == i_ctl.occ;
    assign o_match  = occupied && (r_key == i_key);
    assign o_sh     = i_sh | o_match;
    assign o_key    = r_key;

    // shift toward the oldest end: from the hit onward under LRU, all on eviction
    assign move = occupied &&
                  ((i_ctl.hit && i_ctl.lru && o_sh) || (!i_ctl.hit && i_ctl.full));

    always_comb begin
        n_key = r_key;
        if (i_ctl.upd) begin
            if (move) begin
                n_key = tail ? i_key : i_next_key;
            end else if (!i_ctl.hit && !i_ctl.full && append) begin
                n_key = i_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

`default_nettype wire

// File: rtl/core/crt_seen.sv
`default_nettype none

module crt_seen (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  crt_pkg::t_row       i_rd_row,
    output crt_pkg::t_seen_word o_rd_data,
    input  logic                i_wr_en,
    input  crt_pkg::t_row       i_wr_row,
    input  crt_pkg::t_seen_word i_wr_data,
    output logic                o_clearing
);
    import crt_pkg::*;

    t_seen_word r_mem [SEEN_ROWS];
    t_seen_word r_rd_data;
    t_row       r_clr_row;
    logic       r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clearing) begin
            r_clr_row <= r_clr_row + t_row'(1);
            if (r_clr_row == t_row'(SEEN_ROWS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_row] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire
